[hdl/des_pkg.sv]
// Package for the DES block decryptor: the published DES tables and the
// permutation, key-schedule and round functions that they drive.
// No dependencies; used by des_keysched and des_block_decrypt.
package des_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int HALF_W     = 28;
    localparam int SUBKEY_W   = 48;
    localparam int BLOCK_W    = 64;

    typedef logic [BLOCK_W-1:0]  block_t;
    typedef logic [SUBKEY_W-1:0] subkey_t;
    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [31:0]         word_t;
    typedef logic [NUM_ROUNDS-1:0][SUBKEY_W-1:0] subkey_set_t;

    // Position tables: result bit k (from the MSB) is source bit TAB[k],
    // where source bit 1 is the MSB.
    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
        7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
        7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
        7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

    localparam logic [6:0] PC2_TAB [48] = '{
        7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28,
        7'd15, 7'd6,  7'd21, 7'd10, 7'd23, 7'd19, 7'd12, 7'd4,
        7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
        7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40,
        7'd51, 7'd45, 7'd33, 7'd48, 7'd44, 7'd49, 7'd39, 7'd56,
        7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

    // Total left rotation of each 28-bit half after rounds 1..16.
    localparam logic [4:0] ROT_TOTAL [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8,  7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7,  7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6,  7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5,  7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4,  7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3,  7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2,  7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1,  7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

    // S-boxes, indexed by row * 16 + column.
    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}};

    function automatic logic [55:0] perm_pc1(input block_t src);
        logic [55:0] r;
        for (int k = 0; k < 56; k++)
        begin
            r[55-k] = src[6'(7'd64 - PC1_TAB[k])];
        end
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input logic [55:0] src);
        subkey_t r;
        for (int k = 0; k < 48; k++)
        begin
            r[47-k] = src[6'(7'd56 - PC2_TAB[k])];
        end
        return r;
    endfunction

    function automatic block_t perm_ip(input block_t src);
        block_t r;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = src[6'(7'd64 - IP_TAB[k])];
        end
        return r;
    endfunction

    function automatic block_t perm_fp(input block_t src);
        block_t r;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = src[6'(7'd64 - FP_TAB[k])];
        end
        return r;
    endfunction

    // Left rotation of a 28-bit half by a constant amount of 1 to 28.
    function automatic half_t rot_half(input half_t v, input logic [4:0] amt);
        logic [2*HALF_W-1:0] both;
        both = {v, v} << amt;
        return both[2*HALF_W-1:HALF_W];
    endfunction

    // DES round function: expansion, key mix, S-boxes, P permutation.
    function automatic word_t feistel(input word_t half, input subkey_t key);
        subkey_t    x;
        word_t      sout;
        word_t      r;
        logic [5:0] six;
        for (int k = 0; k < 48; k++)
        begin
            x[47-k] = half[5'(6'd32 - E_TAB[k])];
        end
        x = x ^ key;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47-6*b -: 6];
            sout[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
        end
        for (int k = 0; k < 32; k++)
        begin
            r[31-k] = sout[5'(6'd32 - P_TAB[k])];
        end
        return r;
    endfunction

endpackage

[hdl/des_keysched.sv]
// DES key schedule: turns the key register into the sixteen round subkeys.
// Depends on des_pkg (PC-1, PC-2 and rotation tables).
module des_keysched
    import des_pkg::*;
(
    input  block_t      key,
    output subkey_set_t subkeys
);

    logic [55:0] cd;
    half_t       c0;
    half_t       d0;

    assign cd = perm_pc1(key);
    assign c0 = cd[55:28];
    assign d0 = cd[27:0];

    // Each subkey sees the halves rotated by the running total of shifts,
    // so every round's subkey is pure wiring off the key register.
    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_sub
        assign subkeys[i] = perm_pc2({rot_half(c0, ROT_TOTAL[i]),
                                      rot_half(d0, ROT_TOTAL[i])});
    end

endmodule

[hdl/des_block_decrypt.sv]
// DES single-block decryptor, one Feistel round per pipeline stage.
// Depends on des_pkg and des_keysched.
//
//   channel   signals                          direction  beat
//   input     in_valid, in_stall, cipher_block  in         one ciphertext block
//   output    out_valid, out_stall, plain_block out        one plaintext block
//   config    key_we, cipher_key                in         key write, no handshake
//
// An accepted input beat passes through the sixteen DES rounds, which sit in
// sixteen register stages, one round each; the last stage doubles as the output
// register. One beat can enter every cycle unless all stages are full and the output is stalled.
// Reset clears the stage valid bits and the key register (key zero).
// A stalled output holds only the stages that are full from the output back;
// any empty stage further up still fills, so input is taken while a result waits.
module des_block_decrypt
    import des_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   key_we,
    input  block_t cipher_key,
    input  logic   in_valid,
    output logic   in_stall,
    input  block_t cipher_block,
    output logic   out_valid,
    input  logic   out_stall,
    output block_t plain_block
);

    block_t                key_reg;
    subkey_set_t           subkeys;
    logic [NUM_ROUNDS-1:0] vld_reg;
    logic [NUM_ROUNDS-1:0] adv;
    block_t                lr_reg [NUM_ROUNDS];
    block_t                lr_next [NUM_ROUNDS];

    // The user must write the key only while the pipeline is empty (the block itself
    // does not enforce it), so the subkeys can be taken combinationally from the key register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_we)
        begin
            key_reg <= cipher_key;
        end
    end

    des_keysched u_keysched (
        .key     (key_reg),
        .subkeys (subkeys)
    );

    for (genvar i = 0; i < NUM_ROUNDS; i++)
    begin : g_stage
        block_t src;

        // A stage moves when the output is free or some stage at or below
        // it holds a bubble that the stall can collapse into.
        assign adv[i] = ~(&vld_reg[NUM_ROUNDS-1:i]) | ~out_stall;

        if (i == 0)
        begin : g_first
            assign src = perm_ip(cipher_block);
        end
        else
        begin : g_rest
            assign src = lr_reg[i-1];
        end

        // Decryption uses the subkeys last to first.
        assign lr_next[i] = {src[31:0],
                             src[63:32] ^ feistel(src[31:0], subkeys[NUM_ROUNDS-1-i])};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (adv[i])
            begin
                vld_reg[i] <= (i == 0) ? in_valid : vld_reg[(i == 0) ? 0 : i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                lr_reg[i] <= lr_next[i];
            end
        end
    end

    assign in_stall  = ~adv[0];
    assign out_valid = vld_reg[NUM_ROUNDS-1];

    // Undo the last round's swap, then the inverse initial permutation.
    assign plain_block = perm_fp({lr_reg[NUM_ROUNDS-1][31:0], lr_reg[NUM_ROUNDS-1][63:32]});

endmodule

[tb/des_plaintext_checker.sv]
// Scoreboard for des_block_decrypt: predicts the plaintext of every accepted
// ciphertext beat with its own DES model and checks the output beats in order.
// Depends on des_pkg for the block type only.
`timescale 1ns / 100ps

module des_plaintext_checker
    import des_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   key_we,
    input  block_t cipher_key,
    input  logic   in_valid,
    input  logic   in_stall,
    input  block_t cipher_block,
    input  logic   out_valid,
    input  logic   out_stall,
    input  block_t plain_block,
    output int     fail_count,
    output int     pending
);

    typedef enum int {PERM_PC1, PERM_PC2, PERM_IP, PERM_FP, PERM_E, PERM_P} perm_t;

    localparam int PC1_POS [56] = '{
        57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18, 10, 2,
        59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36, 63, 55, 47, 39,
        31, 23, 15, 7,  62, 54, 46, 38, 30, 22, 14, 6,  61, 53, 45, 37,
        29, 21, 13, 5,  28, 20, 12, 4};
    localparam int PC2_POS [48] = '{
        14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10, 23, 19, 12, 4,
        26, 8,  16, 7,  27, 20, 13, 2,  41, 52, 31, 37, 47, 55, 30, 40,
        51, 45, 33, 48, 44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};
    localparam int IP_POS [64] = '{
        58, 50, 42, 34, 26, 18, 10, 2,  60, 52, 44, 36, 28, 20, 12, 4,
        62, 54, 46, 38, 30, 22, 14, 6,  64, 56, 48, 40, 32, 24, 16, 8,
        57, 49, 41, 33, 25, 17, 9,  1,  59, 51, 43, 35, 27, 19, 11, 3,
        61, 53, 45, 37, 29, 21, 13, 5,  63, 55, 47, 39, 31, 23, 15, 7};
    localparam int FP_POS [64] = '{
        40, 8,  48, 16, 56, 24, 64, 32, 39, 7,  47, 15, 55, 23, 63, 31,
        38, 6,  46, 14, 54, 22, 62, 30, 37, 5,  45, 13, 53, 21, 61, 29,
        36, 4,  44, 12, 52, 20, 60, 28, 35, 3,  43, 11, 51, 19, 59, 27,
        34, 2,  42, 10, 50, 18, 58, 26, 33, 1,  41, 9,  49, 17, 57, 25};
    localparam int E_POS [48] = '{
        32, 1,  2,  3,  4,  5,  4,  5,  6,  7,  8,  9,  8,  9,  10, 11,
        12, 13, 12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21,
        22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};
    localparam int P_POS [32] = '{
        16, 7,  20, 21, 29, 12, 28, 17, 1,  15, 23, 26, 5,  18, 31, 10,
        2,  8,  24, 14, 32, 27, 3,  9,  19, 13, 30, 6,  22, 11, 4,  25};
    localparam int ROT_STEP [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    // Each S-box row packs sixteen 4-bit entries, column 0 in the top nibble.
    localparam logic [63:0] SBOX_ROW [8][4] = '{
        '{64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
          64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D},
        '{64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5,
          64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9},
        '{64'hA09E63F51DC7B428, 64'hD709346A285ECBF1,
          64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C},
        '{64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9,
          64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E},
        '{64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986,
          64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453},
        '{64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38,
          64'h9EF528C3704A1DB6, 64'h432C95FABE17608D},
        '{64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86,
          64'h14BDC37EAF680592, 64'h6BD814A7950FE23C},
        '{64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92,
          64'h7B419CE206ADF358, 64'h21E74A8DFC90356B}};

    localparam logic [63:0] KNOWN_KEY   = 64'h133457799BBCDFF1;
    localparam logic [63:0] KNOWN_CIPH  = 64'h85E813540F0AB405;
    localparam logic [63:0] KNOWN_PLAIN = 64'h0123456789ABCDEF;

    block_t held_key = '0;
    block_t plain_expected [$];
    block_t want;

    function automatic int pos_of(input perm_t sel, input int k);
        case (sel)
            PERM_PC1: return PC1_POS[k];
            PERM_PC2: return PC2_POS[k];
            PERM_IP:  return IP_POS[k];
            PERM_FP:  return FP_POS[k];
            PERM_E:   return E_POS[k];
            default:  return P_POS[k];
        endcase
    endfunction

    // Output bit k from the top takes source bit pos (1 = top of a w-bit value).
    function automatic logic [63:0] scatter(input perm_t sel, input logic [63:0] src,
                                            input int w, input int n);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < n; k++)
        begin
            r = {r[62:0], src[w - pos_of(sel, k)]};
        end
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] v, input int s);
        return (v << s) | (v >> (28 - s));
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] sk);
        logic [63:0] wide;
        logic [47:0] x;
        logic [31:0] s;
        logic [5:0]  six;
        int          row;
        int          col;
        wide = scatter(PERM_E, {32'b0, r}, 32, 48);
        x = wide[47:0] ^ sk;
        for (int b = 0; b < 8; b++)
        begin
            six = x[47 - 6*b -: 6];
            row = int'({six[5], six[0]});
            col = int'(six[4:1]);
            s[31 - 4*b -: 4] = SBOX_ROW[b][row][63 - 4*col -: 4];
        end
        wide = scatter(PERM_P, {32'b0, s}, 32, 32);
        return wide[31:0];
    endfunction

    function automatic logic [63:0] des_decrypt(input logic [63:0] key,
                                                input logic [63:0] ciph);
        logic [63:0] wide;
        logic [47:0] sk [16];
        logic [27:0] c;
        logic [27:0] d;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        wide = scatter(PERM_PC1, key, 64, 56);
        c = wide[55:28];
        d = wide[27:0];
        for (int i = 0; i < 16; i++)
        begin
            c = rot28(c, ROT_STEP[i]);
            d = rot28(d, ROT_STEP[i]);
            wide = scatter(PERM_PC2, {8'b0, c, d}, 56, 48);
            sk[i] = wide[47:0];
        end
        wide = scatter(PERM_IP, ciph, 64, 64);
        l = wide[63:32];
        r = wide[31:0];
        // Decryption walks the subkeys from the last one back to the first.
        for (int i = 0; i < 16; i++)
        begin
            t = l ^ round_fn(r, sk[15 - i]);
            l = r;
            r = t;
        end
        return scatter(PERM_FP, {r, l}, 64, 64);
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        if (des_decrypt(KNOWN_KEY, KNOWN_CIPH) !== KNOWN_PLAIN)
        begin
            $error("predictor: expected %h, actual %h", KNOWN_PLAIN,
                   des_decrypt(KNOWN_KEY, KNOWN_CIPH));
            fail_count++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_key = '0;
            plain_expected.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (plain_expected.size() == 0)
                begin
                    $error("plain_block: expected none, actual %h", plain_block);
                    fail_count++;
                end
                else
                begin
                    want = plain_expected.pop_front();
                    if (plain_block !== want)
                    begin
                        $error("plain_block: expected %h, actual %h", want, plain_block);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                plain_expected.push_back(des_decrypt(held_key, cipher_block));
            end
            if (key_we)
            begin
                held_key = cipher_key;
            end
            pending <= plain_expected.size();
        end
    end

endmodule

[tb/des_block_decrypt_test.sv]
// Top of the des_block_decrypt testbench: clock, reset, key writes, ciphertext
// beats with random idle bursts on both channels, watchdog and verdict.
// Depends on des_pkg, des_block_decrypt and des_plaintext_checker.
`timescale 1ns / 100ps

module des_block_decrypt_test
    import des_pkg::*;
();

    // No beat for this many cycles means the block has hung. The slowest
    // correct stretch is a pipeline fill plus one sender gap and one stall
    // burst, so this is many times over.
    localparam int HANG_LIMIT   = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 72;
    // Settling time after the last result: a bit more than the 16-stage depth.
    localparam int SETTLE_TICKS = 24;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   key_we       = 1'b0;
    block_t cipher_key   = '0;
    logic   in_valid     = 1'b0;
    logic   in_stall;
    block_t cipher_block = '0;
    logic   out_valid;
    logic   out_stall    = 1'b0;
    block_t plain_block;

    int fail_count;
    int pending;
    int quiet_ticks = 0;

    // Chance in percent that a beat is preceded by an idle burst. Both the
    // sender and the output stall use it; zero gives a stretch at full rate.
    int idle_pct = 0;

    always #6 clk = ~clk;

    des_block_decrypt u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_we       (key_we),
        .cipher_key   (cipher_key),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cipher_block (cipher_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_block  (plain_block)
    );

    des_plaintext_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_we       (key_we),
        .cipher_key   (cipher_key),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cipher_block (cipher_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .plain_block  (plain_block),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Offers one ciphertext beat and returns at the edge that takes it. Valid
    // stays high from one beat to the next unless an idle burst is drawn, so
    // it is never dropped and raised again within one time step.
    task automatic send_block(input block_t blk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cipher_block <= blk;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stops sending and waits until every predicted plaintext has come out.
    // The checker's count is registered, so the task waits for the next edge first:
    // a beat taken at the current edge is then already counted.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Key writes happen only with the pipeline empty, so no block in flight
    // can see a key change halfway through its rounds.
    task automatic load_key(input block_t key);
        drain_results();
        key_we     <= 1'b1;
        cipher_key <= key;
        @(posedge clk);
        key_we <= 1'b0;
    endtask

    // Output side: random stall bursts of random length. After each burst
    // the stall stays low across the next edge.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_ticks <= 0;
        end
        else if (quiet_ticks >= HANG_LIMIT)
        begin
            $display("des_block_decrypt verification failed");
            $finish;
        end
        else
        begin
            quiet_ticks <= quiet_ticks + 1;
        end
    end

    initial
    begin
        block_t blk;
        block_t phase_key;
        int     shape;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 25;

        // The key register comes out of reset as zero; these beats rely on it.
        // The last one is the known encryption of an all-zero block under key zero.
        send_block(64'h0000000000000000);
        send_block(64'hFFFFFFFFFFFFFFFF);
        send_block(64'h8CA64DE9C1B123A7);

        // The textbook key and its ciphertext of 0123456789ABCDEF, followed by
        // 0123456789ABCDEF itself and single-bit and alternating patterns.
        load_key(64'h133457799BBCDFF1);
        send_block(64'h85E813540F0AB405);
        send_block(64'h0123456789ABCDEF);
        send_block(64'h8000000000000000);
        send_block(64'h0000000000000001);
        send_block(64'h5555555555555555);
        send_block(64'hAAAAAAAAAAAAAAAA);

        // Same key with the parity bit of the last byte flipped: parity bits
        // are dropped by PC-1, so the plaintext must not change.
        load_key(64'h133457799BBCDFF0);
        send_block(64'h85E813540F0AB405);
        send_block(64'hFEDCBA9876543210);

        // Weak keys are used like any other key.
        load_key(64'h0101010101010101);
        send_block(64'h0000000000000000);
        send_block(64'hFFFFFFFFFFFFFFFF);
        load_key(64'hFEFEFEFEFEFEFEFE);
        send_block(64'h8000000000000000);
        send_block(64'h0000000000000001);

        // Key extremes: all ones, then an explicit write of zero.
        load_key(64'hFFFFFFFFFFFFFFFF);
        send_block(64'h0000000000000000);
        send_block(64'hFFFFFFFFFFFFFFFF);
        send_block(64'h0000000000000001);
        load_key(64'h0000000000000000);
        send_block(64'h8CA64DE9C1B123A7);
        send_block(64'h0123456789ABCDEF);

        // Random part. Each phase loads a new key, which also drains the
        // pipeline before the write. Idle rates vary from phase to phase;
        // some phases and the whole last one run without idling.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                2:       phase_key = '0;
                5:       phase_key = '1;
                default: phase_key = {$urandom, $urandom};
            endcase
            load_key(phase_key);
            if (ph == PHASES - 1 || ph % 3 == 1)
            begin
                idle_pct = 0;
            end
            else
            begin
                idle_pct = $urandom_range(10, 50);
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                // Mostly full random blocks, with some single-bit-set and
                // single-bit-clear blocks at random bit positions.
                shape = $urandom_range(0, 9);
                if (shape == 0)
                begin
                    blk = 64'h1 << $urandom_range(0, 63);
                end
                else if (shape == 1)
                begin
                    blk = ~(64'h1 << $urandom_range(0, 63));
                end
                else
                begin
                    blk = {$urandom, $urandom};
                end
                send_block(blk);
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("des_block_decrypt verification clean");
        end
        else
        begin
            $display("des_block_decrypt verification failed");
        end
        $finish;
    end

endmodule
